>>> hdl/sfp_pkg.sv
package sfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h8A;
  localparam logic [7:0] SYNC_SECOND = 8'hA8;
  localparam logic [7:0] SUM_SEED    = 8'h5A;

  localparam logic [7:0] CMD_A = 8'h12;
  localparam logic [7:0] CMD_B = 8'h81;
  localparam logic [7:0] CMD_C = 8'h84;
  localparam logic [7:0] CMD_D = 8'h85;
  localparam logic [7:0] CMD_E = 8'h86;

  localparam logic [7:0] LEN_A = 8'd1;
  localparam logic [7:0] LEN_B = 8'd5;
  localparam logic [7:0] LEN_C = 8'd2;
  localparam logic [7:0] LEN_E = 8'd17;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_SYNC    = 3'd2;
  localparam logic [2:0] ST_SUM     = 3'd3;
  localparam logic [2:0] ST_LENGTH  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       frame_end;
    logic [2:0] frame_status;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [7:0] length;
  } cmd_info_t;

  // Fixed payload length for each supported command.
  function automatic cmd_info_t cmd_info(input logic [7:0] cmd);
    cmd_info_t info;
    info = '0;
    case (cmd)
      CMD_A: info = '{known: 1'b1, length: LEN_A};
      CMD_B: info = '{known: 1'b1, length: LEN_B};
      CMD_C, CMD_D: info = '{known: 1'b1, length: LEN_C};
      CMD_E: info = '{known: 1'b1, length: LEN_E};
      default: info = '0;
    endcase
    return info;
  endfunction

endpackage

>>> hdl/sfp_in_if.sv
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hdl/sfp_out_if.sv
interface sfp_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_command;
  logic [7:0] frame_length;
  logic       frame_end;
  logic [2:0] frame_status;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_command, output frame_length, output frame_end, output frame_status,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_command, input frame_length, input frame_end, input frame_status,
    output ready
  );
endinterface

>>> hdl/sync_frame_parser_core.sv
// Receive frame parser. Bytes from the serial receiver enter on rx_in, one
// item per byte, and every byte yields exactly one result item on res_out.
// The parser hunts for the sync pair 0x8A 0xA8, then takes a command byte
// and a length byte, reports each payload byte with its index, and checks
// the trailing checksum (0x5A plus the payload bytes, mod 256). The item
// that closes a frame attempt carries frame_end and the final status.
// An accepted byte is first held in the input register; when it moves on,
// the frame state is updated and its result is loaded into the output
// register. Throughput is one byte per cycle while res_out is ready; the
// only loop is the update of the frame state.
// When res_out stalls, the held result stays put and one more byte is still
// taken into the input register; rx_in.ready drops only once both are full.
// A synchronous reset empties both registers and returns the parser to
// hunting for the first sync byte with the checksum reseeded.
module sync_frame_parser_core (
  input  logic      clk,
  input  logic      rst,
  sfp_in_if.sink    rx_in,
  sfp_out_if.source res_out
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Output register.
  logic             out_valid;
  sfp_pkg::result_t out_res;

  sfp_pkg::result_t step_res;
  logic             advance;

  // The input item moves on when the output register is empty or being read.
  assign advance     = in_valid && (!out_valid || res_out.ready);
  assign rx_in.ready = !in_valid || advance;

  sfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_in.ready) begin
      in_valid <= rx_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_in.ready && rx_in.valid) begin
      in_byte <= rx_in.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.payload_valid = out_res.payload_valid;
  assign res_out.payload_byte  = out_res.payload_byte;
  assign res_out.payload_index = out_res.payload_index;
  assign res_out.frame_command = out_res.frame_command;
  assign res_out.frame_length  = out_res.frame_length;
  assign res_out.frame_end     = out_res.frame_end;
  assign res_out.frame_status  = out_res.frame_status;

`ifndef SYNTH
  // A status other than busy appears exactly on the item that ends an attempt.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.frame_status != sfp_pkg::ST_BUSY) == out_res.frame_end))
    else $error("frame_status and frame_end disagree");

  // A payload byte never ends a frame attempt.
  a_payload_not_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.payload_valid && out_res.frame_end))
    else $error("payload byte marked as frame end");

  // A byte held in the input register is not lost or changed while it waits.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte)))
    else $error("input register changed while stalled");

  // A stalled result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_out.ready) |=> (out_valid && $stable(out_res)))
    else $error("output register changed while stalled");
`endif

endmodule

>>> hdl/sfp_frame_fsm.sv
module sfp_frame_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  output sfp_pkg::result_t  result
);

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] command_hold, command_hold_next;
  logic [7:0] length_hold, length_hold_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] count_inc;
  sfp_pkg::cmd_info_t info;

  assign count_inc = byte_count + 8'd1;
  assign info      = sfp_pkg::cmd_info(command_hold);

  always_comb begin
    phase_next        = phase;
    command_hold_next = command_hold;
    length_hold_next  = length_hold;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    result            = '0;

    unique case (phase)
      PH_HUNT2: begin
        if (rx_byte == sfp_pkg::SYNC_SECOND) begin
          phase_next = PH_CMD;
        end else begin
          result.frame_end    = 1'b1;
          result.frame_status = sfp_pkg::ST_SYNC;
        end
      end
      PH_CMD: begin
        command_hold_next = rx_byte;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        length_hold_next = rx_byte;
        byte_count_next  = 8'd0;
        phase_next       = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = byte_count;
        running_sum_next     = running_sum + rx_byte;
        byte_count_next      = count_inc;
        if (count_inc == length_hold) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result.frame_end = 1'b1;
        // A checksum mismatch wins over any command check.
        if (rx_byte != running_sum) begin
          result.frame_status = sfp_pkg::ST_SUM;
        end else if (!info.known) begin
          result.frame_status = sfp_pkg::ST_UNKNOWN;
        end else if (length_hold != info.length) begin
          result.frame_status = sfp_pkg::ST_LENGTH;
        end else begin
          result.frame_status = sfp_pkg::ST_OK;
        end
      end
      default: begin
        phase_next = (rx_byte == sfp_pkg::SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase

    result.frame_command = command_hold_next;
    result.frame_length  = length_hold_next;

    if (result.frame_end) begin
      phase_next        = PH_HUNT1;
      command_hold_next = 8'd0;
      length_hold_next  = 8'd0;
      byte_count_next   = 8'd0;
      running_sum_next  = sfp_pkg::SUM_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT1;
      command_hold <= 8'd0;
      length_hold  <= 8'd0;
      byte_count   <= 8'd0;
      running_sum  <= sfp_pkg::SUM_SEED;
    end else if (advance) begin
      phase        <= phase_next;
      command_hold <= command_hold_next;
      length_hold  <= length_hold_next;
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

>>> tb/sync_frame_parser_core_tb.sv
module sync_frame_parser_core_tb;

  // Run limit in clock cycles. The slowest correct run is about 1500 bytes
  // while the receiver is in its sparse mode, plus sender gaps and one long
  // hold-off.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 100;
  localparam int SEGMENT_BYTES = 300;

  // Parser phases of the predictor. Any other code acts as hunting.
  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_CMD, TAKE_LEN, TAKE_DATA, TAKE_SUM
  } parse_phase_t;

  // Tracks the frame state one byte at a time and keeps the results that the
  // block still owes, oldest first.
  class frame_checker;
    parse_phase_t phase;
    logic [7:0] cmd_held;
    logic [7:0] len_held;
    logic [7:0] count;
    logic [7:0] chk_sum;
    sfp_pkg::result_t pending_results[$];
    int errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase = HUNT_FIRST;
      cmd_held = '0;
      len_held = '0;
      count = '0;
      chk_sum = sfp_pkg::SUM_SEED;
    endfunction

    // Every accepted byte yields exactly one result.
    function void note_rx_byte(logic [7:0] b);
      sfp_pkg::result_t r;
      logic ends;
      int need;
      r = '0;
      r.frame_status = sfp_pkg::ST_BUSY;
      ends = 1'b0;
      case (phase)
        HUNT_SECOND: begin
          if (b == sfp_pkg::SYNC_SECOND) begin
            phase = TAKE_CMD;
          end else begin
            ends = 1'b1;
            r.frame_status = sfp_pkg::ST_SYNC;
          end
        end
        TAKE_CMD: begin
          cmd_held = b;
          phase = TAKE_LEN;
        end
        TAKE_LEN: begin
          len_held = b;
          count = '0;
          phase = (b == 8'd0) ? TAKE_SUM : TAKE_DATA;
        end
        TAKE_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.payload_index = count;
          chk_sum = chk_sum + b;
          count = count + 8'd1;
          if (count == len_held) phase = TAKE_SUM;
        end
        TAKE_SUM: begin
          ends = 1'b1;
          case (cmd_held)
            sfp_pkg::CMD_A: need = int'(sfp_pkg::LEN_A);
            sfp_pkg::CMD_B: need = int'(sfp_pkg::LEN_B);
            sfp_pkg::CMD_C, sfp_pkg::CMD_D: need = int'(sfp_pkg::LEN_C);
            sfp_pkg::CMD_E: need = int'(sfp_pkg::LEN_E);
            default: need = -1;
          endcase
          // The checksum is judged before the command and its length.
          if (b != chk_sum) r.frame_status = sfp_pkg::ST_SUM;
          else if (need < 0) r.frame_status = sfp_pkg::ST_UNKNOWN;
          else if (int'(len_held) != need) r.frame_status = sfp_pkg::ST_LENGTH;
          else r.frame_status = sfp_pkg::ST_OK;
        end
        default: begin
          phase = (b == sfp_pkg::SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
        end
      endcase
      r.frame_command = cmd_held;
      r.frame_length = len_held;
      r.frame_end = ends;
      if (ends) clear_frame();
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(sfp_pkg::result_t got);
      sfp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
        compare_field("payload_byte", want.payload_byte, got.payload_byte);
        compare_field("payload_index", want.payload_index, got.payload_index);
        compare_field("frame_command", want.frame_command, got.frame_command);
        compare_field("frame_length", want.frame_length, got.frame_length);
        compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
        compare_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sfp_in_if rx_if ();
  sfp_out_if res_if ();

  sync_frame_parser_core dut (
    .clk(clk),
    .rst(rst),
    .rx_in(rx_if),
    .res_out(res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_checker frames = new();

  // Bytes waiting to be offered to the block, built one frame at a time.
  logic [7:0] tx_bytes[$];

  // Set by the stimulus to ask the receiver for one long hold-off.
  logic hold_request = 1'b0;

  // Receiver side. Results are sampled at the rising edge, before any
  // assignment made at that edge lands, and ready is then chosen for the next
  // cycle. The stall mode is redrawn periodically: always ready, random
  // stalls, a fixed duty pattern, or mostly stalled.
  int rx_cycle = 0;
  int stall_mode = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    sfp_pkg::result_t got;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.payload_valid, res_if.payload_byte, res_if.payload_index,
                res_if.frame_command, res_if.frame_length, res_if.frame_end,
                res_if.frame_status};
        frames.check_result(got);
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_request) begin
        // The long hold-off lets the block fill both of its registers, so
        // rx_in.ready has to drop while the sender keeps offering bytes.
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= (rx_cycle % 7 < 4);
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one byte and returns at the edge where it was taken. The caller is
  // always at a rising edge, so valid simply stays high from one byte to the
  // next without being lowered in between.
  task automatic send_byte(input logic [7:0] b);
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    frames.note_rx_byte(b);
  endtask

  // Sends everything queued in bursts of random length. A gap of zero is
  // skipped, so valid never falls and rises within the same step.
  task automatic send_stream(input int gap_max);
    int burst;
    int gap;
    while (tx_bytes.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && tx_bytes.size() != 0) begin
        send_byte(tx_bytes.pop_front());
        burst--;
      end
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sender pause: nothing is offered until every owed result has come back.
  task automatic wait_for_results();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (frames.pending_results.size() != 0) @(posedge clk);
  endtask

  // Queues one random piece of traffic: a well-formed frame with random
  // payload, line noise, a broken sync pair, a frame cut short, an unknown
  // command, a wrong length or a bad checksum. With longest set, a full
  // frame of 255 payload bytes is queued instead, which walks the payload
  // index up to 254.
  function automatic void add_random_frame(bit longest);
    int kind;
    int len;
    int right_len;
    int cut;
    logic [7:0] cmd;
    logic [7:0] chk;
    logic [7:0] b;
    kind = longest ? 99 : $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 16) begin
      // A second byte that is not the second sync byte, possibly a first
      // sync byte, which must not start a new frame.
      b = 8'($urandom_range(0, 255));
      if (b == sfp_pkg::SYNC_SECOND) b = sfp_pkg::SYNC_FIRST;
      tx_bytes.push_back(sfp_pkg::SYNC_FIRST);
      tx_bytes.push_back(b);
    end else begin
      case ($urandom_range(0, 11))
        0, 1: begin cmd = sfp_pkg::CMD_A; right_len = int'(sfp_pkg::LEN_A); end
        2, 3: begin cmd = sfp_pkg::CMD_B; right_len = int'(sfp_pkg::LEN_B); end
        4: begin cmd = sfp_pkg::CMD_C; right_len = int'(sfp_pkg::LEN_C); end
        5: begin cmd = sfp_pkg::CMD_D; right_len = int'(sfp_pkg::LEN_C); end
        6, 7: begin cmd = sfp_pkg::CMD_E; right_len = int'(sfp_pkg::LEN_E); end
        default: begin cmd = 8'($urandom_range(0, 255)); right_len = 3; end
      endcase
      case ($urandom_range(0, 99)) inside
        [0:69]: len = right_len;
        [70:98]: len = $urandom_range(0, 20);
        default: len = 255;
      endcase
      if (longest) len = 255;
      // A frame cut short simply runs into whatever follows it.
      cut = (kind < 19 && !longest) ? $urandom_range(0, len) : len + 1;
      tx_bytes.push_back(sfp_pkg::SYNC_FIRST);
      tx_bytes.push_back(sfp_pkg::SYNC_SECOND);
      tx_bytes.push_back(cmd);
      tx_bytes.push_back(8'(len));
      chk = sfp_pkg::SUM_SEED;
      for (int i = 0; i < len && i < cut; i++) begin
        b = 8'($urandom_range(0, 255));
        chk = chk + b;
        tx_bytes.push_back(b);
      end
      if (cut > len) begin
        if ($urandom_range(0, 9) == 0) chk = chk ^ 8'(1 << $urandom_range(0, 7));
        tx_bytes.push_back(chk);
      end
    end
  endfunction

  initial begin
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed traffic: noise at both byte extremes, a bad second sync byte
    // that is itself a first sync byte, a stray second sync byte while
    // hunting, a zero-length frame on a known command (wrong length), a good
    // frame, a checksum error and an unknown command with zero length.
    tx_bytes = {8'h00, 8'hFF,
                sfp_pkg::SYNC_FIRST, sfp_pkg::SYNC_FIRST,
                sfp_pkg::SYNC_SECOND,
                sfp_pkg::SYNC_FIRST, sfp_pkg::SYNC_SECOND, sfp_pkg::CMD_A, 8'h00,
                sfp_pkg::SUM_SEED,
                sfp_pkg::SYNC_FIRST, sfp_pkg::SYNC_SECOND, sfp_pkg::CMD_A,
                sfp_pkg::LEN_A, 8'hFF, 8'(sfp_pkg::SUM_SEED + 8'hFF),
                sfp_pkg::SYNC_FIRST, sfp_pkg::SYNC_SECOND, sfp_pkg::CMD_C,
                sfp_pkg::LEN_C, 8'h00, 8'hFF, 8'h00,
                sfp_pkg::SYNC_FIRST, sfp_pkg::SYNC_SECOND, 8'h00, 8'h00,
                sfp_pkg::SUM_SEED};
    send_stream(3);
    wait_for_results();

    // Random traffic in four segments, each followed by a full drain. The
    // second one runs without sender gaps under a long receiver hold-off,
    // and the last one carries a frame of the largest length.
    for (int seg = 0; seg < 4; seg++) begin
      if (seg == 3) add_random_frame(1'b1);
      while (tx_bytes.size() < SEGMENT_BYTES) add_random_frame(1'b0);
      if (seg == 1) hold_request = 1'b1;
      case (seg)
        0: send_stream(4);
        1: send_stream(0);
        2: send_stream(10);
        default: send_stream(2);
      endcase
      wait_for_results();
    end

    // Allow the input and output registers to show any stray result.
    repeat (8) @(posedge clk);
    if (frames.errors == 0 && frames.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sfp_pkg.sv
hdl/sfp_in_if.sv
hdl/sfp_out_if.sv
hdl/sfp_frame_fsm.sv
hdl/sync_frame_parser_core.sv
tb/sync_frame_parser_core_tb.sv
